### rtl/wcf_pkg.sv
// Shared constants, datapath command codes and control/status bundles.
package wcf_pkg;

  localparam int unsigned SIDE_DEF = 64;

  localparam int unsigned ACT_W  = 2;
  localparam int unsigned SITE_W = 12;
  localparam int unsigned SIZE_W = 13;
  localparam int unsigned BOND_W = 15;
  localparam int unsigned THR_W  = 16;
  localparam int unsigned SEED_W = 32;
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_RUN   = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_WRITE,
    OP_READ,
    OP_READ_CAP,
    OP_CLEAR,
    OP_SEED,
    OP_SEED_CAP,
    OP_NB_RD,
    OP_NB_TEST,
    OP_POP_RD,
    OP_POP_CAP,
    OP_FLIP,
    OP_STAT,
    OP_FIN,
    OP_PUSH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } wcf_cmd_t;

  typedef struct packed {
    logic site_ok;
    logic idx_last;
    logic dir_end;
    logic stack_empty;
    logic out_free;
  } wcf_sts_t;

endpackage

### rtl/wcf_ctrl.sv
// Sequencer that steps the datapath through write, read and cluster runs.
module wcf_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic [wcf_pkg::ACT_W-1:0]       action_i,
  output logic                            in_stall_o,
  input  wcf_pkg::wcf_sts_t               sts_i,
  output wcf_pkg::wcf_cmd_t               cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_WR,
    S_RD,
    S_RD_CAP,
    S_CLR,
    S_SEED,
    S_SEED_CAP,
    S_WALK,
    S_NB_TEST,
    S_POP_CAP,
    S_FLIP,
    S_STAT,
    S_DRAIN,
    S_FIN,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = wcf_pkg::OP_IDLE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = wcf_pkg::OP_LOAD;
          case (action_i)
            wcf_pkg::ACT_WRITE: state_d = S_WR;
            wcf_pkg::ACT_RUN:   state_d = S_CLR;
            wcf_pkg::ACT_READ:  state_d = S_RD;
            default:            state_d = S_DONE;
          endcase
        end
      end
      S_WR: begin
        cmd_o.op = wcf_pkg::OP_WRITE;
        state_d  = S_DONE;
      end
      S_RD: begin
        cmd_o.op = wcf_pkg::OP_READ;
        state_d  = S_RD_CAP;
      end
      S_RD_CAP: begin
        cmd_o.op = wcf_pkg::OP_READ_CAP;
        state_d  = S_DONE;
      end
      S_CLR: begin
        cmd_o.op = wcf_pkg::OP_CLEAR;
        if (sts_i.idx_last) begin
          state_d = sts_i.site_ok ? S_SEED : S_FLIP;
        end
      end
      S_SEED: begin
        cmd_o.op = wcf_pkg::OP_SEED;
        state_d  = S_SEED_CAP;
      end
      S_SEED_CAP: begin
        cmd_o.op = wcf_pkg::OP_SEED_CAP;
        state_d  = S_WALK;
      end
      S_WALK: begin
        if (!sts_i.dir_end) begin
          cmd_o.op = wcf_pkg::OP_NB_RD;
          state_d  = S_NB_TEST;
        end else if (sts_i.stack_empty) begin
          state_d = S_FLIP;
        end else begin
          cmd_o.op = wcf_pkg::OP_POP_RD;
          state_d  = S_POP_CAP;
        end
      end
      S_NB_TEST: begin
        cmd_o.op = wcf_pkg::OP_NB_TEST;
        state_d  = S_WALK;
      end
      S_POP_CAP: begin
        cmd_o.op = wcf_pkg::OP_POP_CAP;
        state_d  = S_WALK;
      end
      S_FLIP: begin
        cmd_o.op = wcf_pkg::OP_FLIP;
        if (sts_i.idx_last) state_d = S_STAT;
      end
      S_STAT: begin
        cmd_o.op = wcf_pkg::OP_STAT;
        if (sts_i.idx_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.op = wcf_pkg::OP_FIN;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.op = wcf_pkg::OP_PUSH;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/wcf_dp.sv
// Lattice, mark and walk memories, random generator, sweep counters and result registers.
module wcf_dp #(
  parameter int unsigned SIDE = wcf_pkg::SIDE_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  wcf_pkg::wcf_cmd_t                  cmd_i,
  output wcf_pkg::wcf_sts_t                  sts_o,
  input  logic [wcf_pkg::SITE_W-1:0]         site_i,
  input  logic                               spin_in_i,
  input  logic [wcf_pkg::THR_W-1:0]          thr_i,
  input  logic                               seed_load_i,
  input  logic [wcf_pkg::SEED_W-1:0]         seed_i,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output logic                               spin_out_o,
  output logic [wcf_pkg::SIZE_W-1:0]         cluster_size_o,
  output logic [wcf_pkg::SIZE_W-1:0]         magnet_abs_o,
  output logic signed [wcf_pkg::BOND_W-1:0]  bond_sum_o
);

  localparam int unsigned NSITES = SIDE * SIDE;
  localparam int unsigned AW     = $clog2(NSITES);
  localparam int unsigned RW     = $clog2(SIDE);

  typedef enum logic [1:0] {
    MARK_FREE = 2'd0,
    MARK_REJ  = 2'd1,
    MARK_IN   = 2'd2
  } mark_e;

  typedef struct packed {
    logic [RW-1:0] row;
    logic [RW-1:0] col;
    logic [2:0]    dir;
  } frame_t;

  // memories
  logic   spin_mem  [NSITES];
  mark_e  mark_mem  [NSITES];
  frame_t stack_mem [NSITES];

  logic   spin_a_q, spin_b_q;
  mark_e  mark_q;
  frame_t stack_q;

  // sweep counter
  logic [AW-1:0] idx_q;
  logic [RW-1:0] irow_q, icol_q;
  logic          idx_last;

  // item and walk state
  logic [wcf_pkg::SITE_W-1:0] site_q;
  logic                       spin_in_q;
  logic [AW-1:0]              site_a;
  logic                       site_ok;
  logic [RW-1:0]              seed_row_q, seed_col_q;
  logic                       seed_spin_q;
  frame_t                     cur_q;
  logic [AW:0]                depth_q;
  logic [RW-1:0]              nb_row_q, nb_col_q;
  logic [AW-1:0]              nb_addr_q;
  logic [RW-1:0]              nb_row, nb_col;
  logic [AW-1:0]              nb_addr;
  logic [31:0]                rng_q, rng_x1, rng_x2, rng_x3;
  logic                       join_ok, nb_match;

  // statistics
  logic [AW:0]   count_q, ups_q;
  logic [AW+1:0] agree_q;
  logic [1:0]    agree_inc;
  logic          prev_q, first_q;
  logic          flip_v_q, stat_v_q;
  logic [AW-1:0] flip_addr_q;
  logic [RW-1:0] srow_q;
  logic [AW-1:0] right_addr;
  logic signed [AW+2:0] mag_s, mag_abs;
  logic signed [AW+3:0] bond_s;

  // results and output word
  logic                               res_spin_q;
  logic [wcf_pkg::SIZE_W-1:0]         res_size_q, res_mag_q;
  logic signed [wcf_pkg::BOND_W-1:0]  res_bond_q;
  logic                               out_valid_q;

  // memory port controls
  logic          sp_we, sp_wd;
  logic [AW-1:0] sp_wa, sp_ra;
  logic          mk_we;
  logic [AW-1:0] mk_wa, mk_ra;
  mark_e         mk_wd;
  logic          st_we;
  logic [AW-1:0] st_a;

  assign site_a   = AW'(site_q);
  assign site_ok  = (32'(site_q) < 32'(NSITES));
  assign idx_last = (idx_q == AW'(NSITES - 1));

  assign sts_o.site_ok     = site_ok;
  assign sts_o.idx_last    = idx_last;
  assign sts_o.dir_end     = cur_q.dir[2];
  assign sts_o.stack_empty = (depth_q == '0);
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

  // xorshift step
  assign rng_x1  = rng_q ^ (rng_q << 13);
  assign rng_x2  = rng_x1 ^ (rng_x1 >> 17);
  assign rng_x3  = rng_x2 ^ (rng_x2 << 5);
  assign join_ok = (thr_i > rng_x3[31:16]);
  assign nb_match = (spin_a_q == seed_spin_q) && (mark_q == MARK_FREE);

  // neighbor of the current site: top, bottom, left, right
  always_comb begin
    nb_row = cur_q.row;
    nb_col = cur_q.col;
    case (cur_q.dir[1:0])
      2'd0: nb_row = (cur_q.row == '0) ? RW'(SIDE - 1) : cur_q.row - 1'b1;
      2'd1: nb_row = (cur_q.row == RW'(SIDE - 1)) ? '0 : cur_q.row + 1'b1;
      2'd2: nb_col = (cur_q.col == '0) ? RW'(SIDE - 1) : cur_q.col - 1'b1;
      default: nb_col = (cur_q.col == RW'(SIDE - 1)) ? '0 : cur_q.col + 1'b1;
    endcase
  end

  assign nb_addr    = AW'(AW'(nb_col) * AW'(SIDE) + AW'(nb_row));
  assign right_addr = (icol_q == RW'(SIDE - 1)) ? AW'(irow_q) : AW'(idx_q + AW'(SIDE));

  always_comb begin
    sp_we = 1'b0;
    sp_wa = site_a;
    sp_wd = spin_in_q;
    sp_ra = site_a;
    mk_we = 1'b0;
    mk_wa = idx_q;
    mk_wd = MARK_FREE;
    mk_ra = idx_q;
    st_we = 1'b0;
    st_a  = depth_q[AW-1:0];
    if (flip_v_q && mark_q == MARK_IN) begin
      sp_we = 1'b1;
      sp_wa = flip_addr_q;
      sp_wd = ~spin_a_q;
    end
    unique case (cmd_i.op)
      wcf_pkg::OP_WRITE: begin
        sp_we = site_ok;
      end
      wcf_pkg::OP_CLEAR: begin
        mk_we = 1'b1;
      end
      wcf_pkg::OP_SEED: begin
        mk_we = 1'b1;
        mk_wa = site_a;
        mk_wd = MARK_IN;
      end
      wcf_pkg::OP_NB_RD: begin
        sp_ra = nb_addr;
        mk_ra = nb_addr;
      end
      wcf_pkg::OP_NB_TEST: begin
        mk_we = nb_match;
        mk_wa = nb_addr_q;
        mk_wd = join_ok ? MARK_IN : MARK_REJ;
        st_we = nb_match && join_ok;
      end
      wcf_pkg::OP_POP_RD: begin
        st_a = AW'(depth_q - 1'b1);
      end
      wcf_pkg::OP_FLIP, wcf_pkg::OP_STAT: begin
        sp_ra = idx_q;
      end
      default: begin
      end
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (sp_we) spin_mem[sp_wa] <= sp_wd;
    spin_a_q <= spin_mem[sp_ra];
    spin_b_q <= spin_mem[right_addr];
  end

  always_ff @(posedge clk_i) begin
    if (mk_we) mark_mem[mk_wa] <= mk_wd;
    mark_q <= mark_mem[mk_ra];
  end

  always_ff @(posedge clk_i) begin
    if (st_we) stack_mem[st_a] <= cur_q;
    stack_q <= stack_mem[st_a];
  end

  assign agree_inc = 2'((spin_a_q == spin_b_q))
                   + 2'((srow_q != '0) && (spin_a_q == prev_q))
                   + 2'((srow_q == RW'(SIDE - 1)) && (spin_a_q == first_q));

  assign mag_s   = $signed({1'b0, ups_q, 1'b0}) - $signed((AW + 3)'(NSITES));
  assign mag_abs = (mag_s < 0) ? -mag_s : mag_s;
  assign bond_s  = $signed({1'b0, agree_q, 1'b0}) - $signed((AW + 4)'(2 * NSITES));

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      irow_q      <= '0;
      icol_q      <= '0;
      depth_q     <= '0;
      rng_q       <= 32'd1;
      flip_v_q    <= 1'b0;
      stat_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      flip_v_q <= (cmd_i.op == wcf_pkg::OP_FLIP);
      stat_v_q <= (cmd_i.op == wcf_pkg::OP_STAT);
      // advance the sweep; every sweep covers the whole lattice and wraps to zero
      if (cmd_i.op == wcf_pkg::OP_CLEAR || cmd_i.op == wcf_pkg::OP_FLIP ||
          cmd_i.op == wcf_pkg::OP_STAT) begin
        if (idx_last) begin
          idx_q  <= '0;
          irow_q <= '0;
          icol_q <= '0;
        end else begin
          idx_q <= idx_q + 1'b1;
          if (irow_q == RW'(SIDE - 1)) begin
            irow_q <= '0;
            icol_q <= icol_q + 1'b1;
          end else begin
            irow_q <= irow_q + 1'b1;
          end
        end
      end
      if (seed_load_i) begin
        rng_q <= (seed_i == '0) ? 32'd1 : seed_i;
      end else if (cmd_i.op == wcf_pkg::OP_NB_TEST && nb_match) begin
        rng_q <= rng_x3;
      end
      case (cmd_i.op)
        wcf_pkg::OP_SEED:   depth_q <= '0;
        wcf_pkg::OP_POP_RD: depth_q <= depth_q - 1'b1;
        wcf_pkg::OP_NB_TEST: begin
          if (nb_match && join_ok) depth_q <= depth_q + 1'b1;
        end
        default: begin
        end
      endcase
      if (cmd_i.op == wcf_pkg::OP_PUSH) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (stat_v_q) begin
      ups_q   <= ups_q + (AW + 1)'(spin_a_q);
      agree_q <= agree_q + (AW + 2)'(agree_inc);
      prev_q  <= spin_a_q;
      if (srow_q == '0) first_q <= spin_a_q;
    end
    srow_q      <= irow_q;
    flip_addr_q <= idx_q;
    if (cmd_i.op == wcf_pkg::OP_CLEAR && idx_q == site_a) begin
      seed_row_q <= irow_q;
      seed_col_q <= icol_q;
    end
    case (cmd_i.op)
      wcf_pkg::OP_LOAD: begin
        site_q     <= site_i;
        spin_in_q  <= spin_in_i;
        res_spin_q <= 1'b0;
        res_size_q <= '0;
        res_mag_q  <= '0;
        res_bond_q <= '0;
        count_q    <= '0;
        ups_q      <= '0;
        agree_q    <= '0;
      end
      wcf_pkg::OP_READ_CAP: begin
        res_spin_q <= site_ok & spin_a_q;
      end
      wcf_pkg::OP_SEED: begin
        cur_q   <= '{row: seed_row_q, col: seed_col_q, dir: 3'd0};
        count_q <= (AW + 1)'(1);
      end
      wcf_pkg::OP_SEED_CAP: begin
        seed_spin_q <= spin_a_q;
      end
      wcf_pkg::OP_NB_RD: begin
        nb_row_q  <= nb_row;
        nb_col_q  <= nb_col;
        nb_addr_q <= nb_addr;
        cur_q.dir <= cur_q.dir + 1'b1;
      end
      wcf_pkg::OP_NB_TEST: begin
        // descend into a joined neighbor at once
        if (nb_match && join_ok) begin
          cur_q   <= '{row: nb_row_q, col: nb_col_q, dir: 3'd0};
          count_q <= count_q + 1'b1;
        end
      end
      wcf_pkg::OP_POP_CAP: begin
        cur_q <= stack_q;
      end
      wcf_pkg::OP_FIN: begin
        res_size_q <= wcf_pkg::SIZE_W'(count_q);
        res_mag_q  <= wcf_pkg::SIZE_W'(mag_abs);
        res_bond_q <= wcf_pkg::BOND_W'(bond_s);
      end
      wcf_pkg::OP_PUSH: begin
        spin_out_o     <= res_spin_q;
        cluster_size_o <= res_size_q;
        magnet_abs_o   <= res_mag_q;
        bond_sum_o     <= res_bond_q;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/wolff_cluster_flip_engine_unit.sv
// Wolff cluster flip engine: top level with register port, sequencer and datapath.
// A cluster run makes three full-lattice sweeps (clear marks, flip, statistics); between the
// first two it walks the cluster, reading then testing each neighbor and reading then
// capturing each pop of the walk stack. A seed outside the lattice skips the walk.
// One word is in flight at a time; the next is taken once the result sits in the output register.
// Reset (rst_ni low, asynchronous) idles the sequencer, empties the output and sets
// join_threshold to 0, rng_seed and the generator to 1; spin memory is undefined until written.
module wolff_cluster_flip_engine_unit #(
  parameter int unsigned SIDE = wcf_pkg::SIDE_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // item channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [wcf_pkg::ACT_W-1:0]          action_i,
  input  logic [wcf_pkg::SITE_W-1:0]         site_i,
  input  logic                               spin_in_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               spin_out_o,
  output logic [wcf_pkg::SIZE_W-1:0]         cluster_size_o,
  output logic [wcf_pkg::SIZE_W-1:0]         magnet_abs_o,
  output logic signed [wcf_pkg::BOND_W-1:0]  bond_sum_o,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wcf_pkg::APB_AW-1:0]         paddr,
  input  logic [wcf_pkg::APB_DW-1:0]         pwdata,
  output logic [wcf_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);

  wcf_pkg::wcf_cmd_t cmd;
  wcf_pkg::wcf_sts_t sts;

  logic [wcf_pkg::THR_W-1:0]  thr_q;
  logic [wcf_pkg::SEED_W-1:0] seed_q;
  logic                       cfg_wr;
  logic                       seed_load;

  // Registers: join_threshold at byte 0, rng_seed at byte 4. Address bit 2 selects.
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign seed_load = cfg_wr && paddr[2];
  assign prdata    = paddr[2] ? seed_q : wcf_pkg::APB_DW'(thr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= '0;
      seed_q <= wcf_pkg::SEED_W'(1);
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        seed_q <= pwdata;
      end else begin
        thr_q <= pwdata[wcf_pkg::THR_W-1:0];
      end
    end
  end

  // Sequencer: one word at a time, steps the datapath through each phase.
  wcf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: lattice, marks, walk stack, generator, statistics and output register.
  wcf_dp #(
    .SIDE (SIDE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .site_i         (site_i),
    .spin_in_i      (spin_in_i),
    .thr_i          (thr_q),
    .seed_load_i    (seed_load),
    .seed_i         (pwdata),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .spin_out_o     (spin_out_o),
    .cluster_size_o (cluster_size_o),
    .magnet_abs_o   (magnet_abs_o),
    .bond_sum_o     (bond_sum_o)
  );

  // A stalled result word holds, unchanged, until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
      $stable({spin_out_o, cluster_size_o, magnet_abs_o, bond_sum_o}))
    else $error("stalled result word changed");

  // A spin read reports no cluster figures.
  a_read_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && spin_out_o |-> cluster_size_o == '0 && bond_sum_o == '0)
    else $error("read result carries cluster figures");

  // The bond sum counts 2N edges of +1 or -1, so it is always even.
  a_bond_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !bond_sum_o[0])
    else $error("odd bond sum");

  // No word enters while an earlier word is still in the sequencer.
  a_busy_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item accepted back to back");

endmodule

### tb/wolff_cluster_flip_engine_unit_test.sv
// Self-checking regression for the Wolff cluster flip engine.
module wolff_cluster_flip_engine_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SIDE   = 64;
  localparam int unsigned NSITES = SIDE * SIDE;
  localparam int unsigned WD_LIMIT = 200000;

  // register addresses
  localparam logic [wcf_pkg::APB_AW-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [wcf_pkg::APB_AW-1:0] REG_SEED      = 3'd4;

  typedef struct packed {
    logic                              spin;
    logic [wcf_pkg::SIZE_W-1:0]        size;
    logic [wcf_pkg::SIZE_W-1:0]        mag;
    logic signed [wcf_pkg::BOND_W-1:0] bond;
  } lattice_word_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o;
  logic [wcf_pkg::ACT_W-1:0] action_i;
  logic [wcf_pkg::SITE_W-1:0] site_i;
  logic spin_in_i;
  logic out_valid_o, out_stall_i;
  logic spin_out_o;
  logic [wcf_pkg::SIZE_W-1:0] cluster_size_o, magnet_abs_o;
  logic signed [wcf_pkg::BOND_W-1:0] bond_sum_o;
  logic psel, penable, pwrite, pready;
  logic [wcf_pkg::APB_AW-1:0] paddr;
  logic [wcf_pkg::APB_DW-1:0] pwdata, prdata;

  wolff_cluster_flip_engine_unit #(.SIDE(SIDE)) DUT (.*);

  // predictor state
  bit              lattice [NSITES];
  bit              written [NSITES];
  logic [1:0]      marks   [NSITES];
  int unsigned     trail   [NSITES];
  logic [15:0]     threshold;
  logic [31:0]     xorshift;
  lattice_word_t   pending_words [$];

  int unsigned errors;
  int unsigned idle_cycles;
  int unsigned send_idle_pct, recv_idle_pct;
  bit          recv_hold;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [15:0] next_draw();
    logic [31:0] x;
    x = xorshift;
    x ^= x << 13;
    x ^= x >> 17;
    x ^= x << 5;
    xorshift = x;
    return x[31:16];
  endfunction

  function automatic int unsigned adjacent(int unsigned i, int unsigned dir);
    case (dir)
      0: return (i % SIDE == 0) ? i + SIDE - 1 : i - 1;
      1: return (i % SIDE == SIDE - 1) ? i - SIDE + 1 : i + 1;
      2: return (i < SIDE) ? NSITES - SIDE + i : i - SIDE;
      default: return (i >= NSITES - SIDE) ? i % SIDE : i + SIDE;
    endcase
  endfunction

  function automatic int unsigned grow_cluster(int unsigned seed);
    int unsigned count, depth, s, d, n;
    count = 1;
    depth = 1;
    foreach (marks[k]) marks[k] = 2'd0;
    marks[seed] = 2'd2;
    trail[0] = seed << 3;
    while (depth > 0) begin
      s = trail[depth-1] >> 3;
      d = trail[depth-1] & 7;
      if (d >= 4) begin
        depth--;
        continue;
      end
      trail[depth-1]++;
      n = adjacent(s, d);
      if (lattice[n] == lattice[s] && marks[n] == 2'd0) begin
        if (threshold > next_draw()) begin
          marks[n] = 2'd2;
          count++;
          if (depth < NSITES) trail[depth++] = n << 3;
        end else begin
          marks[n] = 2'd1;
        end
      end
    end
    foreach (lattice[k]) if (marks[k] == 2'd2) lattice[k] = ~lattice[k];
    return count;
  endfunction

  // compute the result word an accepted input word must produce
  function automatic lattice_word_t predict_word(logic [wcf_pkg::ACT_W-1:0] act,
                                                 int unsigned site, bit spin);
    lattice_word_t w;
    int mag, bond, sv;
    int unsigned count;
    w = '0;
    if (act == wcf_pkg::ACT_WRITE) begin
      if (site < NSITES) lattice[site] = spin;
    end else if (act == wcf_pkg::ACT_READ) begin
      if (site < NSITES) w.spin = lattice[site];
    end else if (act == wcf_pkg::ACT_RUN) begin
      count = (site < NSITES) ? grow_cluster(site) : 0;
      mag = 0;
      bond = 0;
      for (int unsigned i = 0; i < NSITES; i++) begin
        sv = lattice[i] ? 1 : -1;
        mag += sv;
        bond += sv * (lattice[adjacent(i, 0)] ? 1 : -1)
              + sv * (lattice[adjacent(i, 3)] ? 1 : -1);
      end
      if (mag < 0) mag = -mag;
      w.size = count[wcf_pkg::SIZE_W-1:0];
      w.mag  = mag[wcf_pkg::SIZE_W-1:0];
      w.bond = bond[wcf_pkg::BOND_W-1:0];
    end
    return w;
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= recv_hold || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // compare every accepted result word with the oldest expectation
  always @(posedge clk_i) begin
    lattice_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        $error("result word with no expectation");
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (spin_out_o !== want.spin) begin
          $error("spin_out: expected %0d actual %0d", want.spin, spin_out_o);
          errors++;
        end
        if (cluster_size_o !== want.size) begin
          $error("cluster_size: expected %0d actual %0d", want.size, cluster_size_o);
          errors++;
        end
        if (magnet_abs_o !== want.mag) begin
          $error("magnet_abs: expected %0d actual %0d", want.mag, magnet_abs_o);
          errors++;
        end
        if (bond_sum_o !== want.bond) begin
          $error("bond_sum: expected %0d actual %0d", want.bond, bond_sum_o);
          errors++;
        end
      end
    end
  end

  // watchdog: count cycles with no handshake on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WD_LIMIT) begin
      $display("wolff_cluster_flip_engine_unit regression: fail");
      $finish;
    end
  end

  // offer one word and hold it until accepted; drop valid only while idling
  task automatic send_word(logic [wcf_pkg::ACT_W-1:0] act, logic [wcf_pkg::SITE_W-1:0] site,
                           bit spin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    site_i     <= site;
    spin_in_i  <= spin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_words.push_back(predict_word(act, site, spin));
    if (act == wcf_pkg::ACT_WRITE && site < NSITES) written[site] = 1'b1;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [wcf_pkg::APB_AW-1:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == REG_THRESHOLD) threshold = data[15:0];
    else xorshift = (data == 0) ? 32'd1 : data;
    @(posedge clk_i);
  endtask

  // pick a site that has been written, so no undefined spin is ever used
  function automatic logic [wcf_pkg::SITE_W-1:0] any_written_site();
    int unsigned s;
    do s = $urandom_range(NSITES - 1); while (!written[s]);
    return wcf_pkg::SITE_W'(s);
  endfunction

  // fill the whole lattice so every later read or cluster run is defined
  task automatic test_fill_lattice();
    for (int unsigned i = 0; i < NSITES; i++) begin
      send_word(wcf_pkg::ACT_WRITE, wcf_pkg::SITE_W'(i), 1'($urandom_range(1)));
    end
    drain_results();
  endtask

  task automatic test_directed();
    send_word(wcf_pkg::ACT_WRITE, 12'd0, 1'b1);
    send_word(wcf_pkg::ACT_WRITE, 12'hFFF, 1'b0);
    send_word(wcf_pkg::ACT_READ, 12'd0, 1'b0);
    send_word(wcf_pkg::ACT_READ, 12'hFFF, 1'b1);
    send_word(wcf_pkg::ACT_NONE, 12'd5, 1'b1);
    send_word(wcf_pkg::ACT_RUN, 12'd0, 1'b0);     // threshold 0: lone seed flips
    drain_results();
    reg_write(REG_THRESHOLD, 32'hFFFF);           // near-certain joins
    reg_write(REG_SEED, 32'd0);                   // zero seed falls back to one
    send_word(wcf_pkg::ACT_RUN, 12'hFFF, 1'b0);
    send_word(wcf_pkg::ACT_RUN, 12'd63, 1'b1);    // corner wraparound
    send_word(wcf_pkg::ACT_READ, 12'd63, 1'b0);
    drain_results();
    reg_write(REG_SEED, 32'hFFFF_FFFF);
    reg_write(REG_THRESHOLD, 32'h8000);
    send_word(wcf_pkg::ACT_RUN, 12'd2048, 1'b1);
    send_word(wcf_pkg::ACT_WRITE, 12'd4032, 1'b1);
    send_word(wcf_pkg::ACT_READ, 12'd4032, 1'b0);
    drain_results();
  endtask

  task automatic random_words(int unsigned n);
    logic [wcf_pkg::ACT_W-1:0] act;
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(9) < 2) act = wcf_pkg::ACT_RUN;
      else if ($urandom_range(2) == 1) act = wcf_pkg::ACT_READ;
      else act = wcf_pkg::ACT_WRITE;
      if ($urandom_range(19) == 0) act = wcf_pkg::ACT_NONE;
      if ($urandom_range(29) == 0) act = wcf_pkg::ACT_W'($urandom_range(3));
      send_word(act, any_written_site(), 1'($urandom_range(1)));
    end
  endtask

  task automatic test_random_phase(int unsigned s_pct, int unsigned r_pct,
                                   logic [31:0] thr, logic [31:0] seed);
    reg_write(REG_THRESHOLD, thr);
    reg_write(REG_SEED, seed);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    random_words(33);
    drain_results();
  endtask

  // hold the receiver off long enough that the input stalls behind it
  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1'b1;
        repeat (400) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      for (int unsigned k = 0; k < 6; k++) begin
        send_word(wcf_pkg::ACT_READ, any_written_site(), 1'b0);
      end
    join
    drain_results();  // sender pauses until every result is back
  endtask

  initial begin
    errors = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 1'b0;
    threshold = '0;
    xorshift = 32'd1;
    foreach (lattice[k]) begin
      lattice[k] = 1'b0;
      written[k] = 1'b0;
    end
    in_valid_i = 1'b0;
    action_i = '0;
    site_i = '0;
    spin_in_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fill_lattice();
    test_directed();
    test_random_phase(6, 47, 32'h0000, 32'h1234_5678);
    test_random_phase(47, 6, 32'hFFFF, 32'h0000_0001);
    test_random_phase(0, 0, 32'h9E00, 32'hDEAD_BEEF);
    test_backpressure();

    if (errors == 0) begin
      $display("wolff_cluster_flip_engine_unit regression: pass");
    end else begin
      $display("wolff_cluster_flip_engine_unit regression: fail");
    end
    $finish;
  end
endmodule
